FILE: sv/iag_pkg.sv
package iag_pkg;

	// Field and counter widths
	localparam int SIZE_W      = 11;
	localparam int PAD_W       = 4;
	localparam int STEP_W      = 4;
	localparam int KPOS_W      = 4;
	localparam int CHAN_W      = 10;
	localparam int POS_W       = 11;
	localparam int OFF_W       = 11;
	localparam int SPAN_W      = 12;
	localparam int LIN_W       = 38;
	localparam int BASE_W      = 32;
	localparam int ADDR_W      = 33;
	localparam int CHH_W       = 21;
	localparam int PROD_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int OUT_DATA_W  = 72;
	localparam int OUT_USER_W  = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Largest image size; larger writes saturate here
	localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_ROWS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_COLS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_ROWS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COLS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SCATTER_MODE  = 3'd7;

	// Image geometry the address unit needs
	typedef struct packed {
		logic [SIZE_W-1:0] image_height;
		logic [SIZE_W-1:0] image_width;
		logic [PAD_W-1:0]  pad_rows;
		logic [PAD_W-1:0]  pad_cols;
	} geom_t;

	// One classified element, front to back
	typedef struct packed {
		logic              bad;
		logic              last;
		logic [LIN_W-1:0]  col_index;
		logic [CHAN_W-1:0] chan;
		logic [KPOS_W-1:0] krow;
		logic [KPOS_W-1:0] kcol;
		logic [OFF_W-1:0]  row_off;
		logic [OFF_W-1:0]  col_off;
		logic [BASE_W-1:0] base;
	} elem_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: sv/iag_front.sv
module iag_front #(
	parameter int KERNEL_ROWS = 3,
	parameter int KERNEL_COLS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [iag_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [iag_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [iag_pkg::BASE_W-1:0]          s_tdata,
	input  logic                                s_tuser,
	input  iag_pkg::q_stat_t                    q_stat,
	output logic                                push,
	output iag_pkg::elem_t                      elem,
	output iag_pkg::geom_t                      geom
);

	localparam int SW = iag_pkg::SIZE_W;
	localparam int PW = iag_pkg::PAD_W;
	localparam int TW = iag_pkg::STEP_W;
	localparam int KW = iag_pkg::KPOS_W;
	localparam int CW = iag_pkg::CHAN_W;
	localparam int OW = iag_pkg::POS_W;
	localparam int FW = iag_pkg::OFF_W;
	localparam int NW = iag_pkg::SPAN_W;
	localparam int LW = iag_pkg::LIN_W;
	localparam int MW = OW + TW;
	localparam logic [KW-1:0] KR = KW'(KERNEL_ROWS);
	localparam logic [KW-1:0] KC = KW'(KERNEL_COLS);

	typedef struct packed {
		logic [NW-1:0] lim_r;
		logic [NW-1:0] lim_c;
		logic          bad;
	} limits_t;

	logic [SW-1:0] ch_cnt_q, height_q, width_q;
	logic [PW-1:0] pad_r_q, pad_c_q;
	logic [TW-1:0] step_r_q, step_c_q;
	logic          settle_q;
	limits_t       lim_d, lim_q;

	logic [CW-1:0] chan_q, chan_d;
	logic [KW-1:0] krow_q, krow_d, kcol_q, kcol_d;
	logic [OW-1:0] orow_q, orow_d, ocol_q, ocol_d;
	logic [LW-1:0] lin_q, lin_d;

	logic [NW-1:0] span_r, span_c;
	logic [MW-1:0] row_off, col_off, e_row_off, e_col_off;
	logic [MW:0]   row_nx, col_nx;
	logic [CW-1:0] e_chan;
	logic [KW-1:0] e_krow, e_kcol;
	logic [OW-1:0] e_orow, e_ocol;
	logic [LW-1:0] e_lin;
	logic          stale, clear, last;
	logic          chan_more, krow_more, kcol_more, row_more, col_more;

	function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v);
		return (v > iag_pkg::SIZE_MAX) ? iag_pkg::SIZE_MAX : v;
	endfunction

	// Capture register writes; the mode bit selects nothing inside this block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_cnt_q <= SW'(1);
			height_q <= SW'(1);
			width_q  <= SW'(1);
			pad_r_q  <= '0;
			pad_c_q  <= '0;
			step_r_q <= TW'(1);
			step_c_q <= TW'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				iag_pkg::CFG_CHANNEL_COUNT: ch_cnt_q <= clamp_size(cfg_data);
				iag_pkg::CFG_IMAGE_HEIGHT:  height_q <= clamp_size(cfg_data);
				iag_pkg::CFG_IMAGE_WIDTH:   width_q  <= clamp_size(cfg_data);
				iag_pkg::CFG_PAD_ROWS:      pad_r_q  <= cfg_data[PW-1:0];
				iag_pkg::CFG_PAD_COLS:      pad_c_q  <= cfg_data[PW-1:0];
				iag_pkg::CFG_STEP_ROWS:     step_r_q <= cfg_data[TW-1:0];
				iag_pkg::CFG_STEP_COLS:     step_c_q <= cfg_data[TW-1:0];
				iag_pkg::CFG_SCATTER_MODE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Derive placement limits from the registers
	always_comb begin
		span_r = NW'(height_q) + NW'({pad_r_q, 1'b0});
		span_c = NW'(width_q) + NW'({pad_c_q, 1'b0});
		lim_d.lim_r = span_r - NW'(KR);
		lim_d.lim_c = span_c - NW'(KC);
		lim_d.bad = (ch_cnt_q == '0) || (height_q == '0) || (width_q == '0) ||
			(step_r_q == '0) || (step_c_q == '0) ||
			(NW'(KR) > span_r) || (NW'(KC) > span_c);
	end

	always_ff @(posedge clk) begin
		lim_q <= lim_d;
	end

	// Hold off requests after reset and in the cycle after a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_write;
		end
	end

	assign s_tready = !q_stat.full && !settle_q;
	assign push     = s_tvalid && s_tready;

	// Classify the current position: restart, stale counters, final element
	always_comb begin
		row_off = MW'(orow_q) * MW'(step_r_q);
		col_off = MW'(ocol_q) * MW'(step_c_q);
		stale = (SW'(chan_q) >= ch_cnt_q) || (krow_q >= KR) || (kcol_q >= KC) ||
			(row_off > MW'(lim_q.lim_r)) || (col_off > MW'(lim_q.lim_c));
		clear = s_tuser || stale;

		e_chan    = clear ? '0 : chan_q;
		e_krow    = clear ? '0 : krow_q;
		e_kcol    = clear ? '0 : kcol_q;
		e_orow    = clear ? '0 : orow_q;
		e_ocol    = clear ? '0 : ocol_q;
		e_lin     = clear ? '0 : lin_q;
		e_row_off = clear ? '0 : row_off;
		e_col_off = clear ? '0 : col_off;

		row_nx    = (MW+1)'(e_row_off) + (MW+1)'(step_r_q);
		col_nx    = (MW+1)'(e_col_off) + (MW+1)'(step_c_q);
		row_more  = row_nx <= (MW+1)'(lim_q.lim_r);
		col_more  = col_nx <= (MW+1)'(lim_q.lim_c);
		kcol_more = (e_kcol + KW'(1)) < KC;
		krow_more = (e_krow + KW'(1)) < KR;
		chan_more = (SW'(e_chan) + SW'(1)) != ch_cnt_q;
		last = !chan_more && !krow_more && !kcol_more && !row_more && !col_more;
	end

	// Advance the nested walk, fastest over output columns
	always_comb begin
		chan_d = e_chan;
		krow_d = e_krow;
		kcol_d = e_kcol;
		orow_d = e_orow;
		ocol_d = e_ocol;
		lin_d  = e_lin + LW'(1);
		priority if (lim_q.bad || last) begin
			chan_d = '0;
			krow_d = '0;
			kcol_d = '0;
			orow_d = '0;
			ocol_d = '0;
			lin_d  = '0;
		end else if (col_more) begin
			ocol_d = e_ocol + OW'(1);
		end else if (row_more) begin
			ocol_d = '0;
			orow_d = e_orow + OW'(1);
		end else if (kcol_more) begin
			ocol_d = '0;
			orow_d = '0;
			kcol_d = e_kcol + KW'(1);
		end else if (krow_more) begin
			ocol_d = '0;
			orow_d = '0;
			kcol_d = '0;
			krow_d = e_krow + KW'(1);
		end else begin
			ocol_d = '0;
			orow_d = '0;
			kcol_d = '0;
			krow_d = '0;
			chan_d = e_chan + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			krow_q <= '0;
			kcol_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			lin_q  <= '0;
		end else if (push) begin
			chan_q <= chan_d;
			krow_q <= krow_d;
			kcol_q <= kcol_d;
			orow_q <= orow_d;
			ocol_q <= ocol_d;
			lin_q  <= lin_d;
		end
	end

	// Element record for the address unit; offsets never exceed the limits
	always_comb begin
		elem.bad       = lim_q.bad;
		elem.last      = last;
		elem.col_index = e_lin;
		elem.chan      = e_chan;
		elem.krow      = e_krow;
		elem.kcol      = e_kcol;
		elem.row_off   = e_row_off[FW-1:0];
		elem.col_off   = e_col_off[FW-1:0];
		elem.base      = s_tdata;
	end

	assign geom.image_height = height_q;
	assign geom.image_width  = width_q;
	assign geom.pad_rows     = pad_r_q;
	assign geom.pad_cols     = pad_c_q;

endmodule

FILE: sv/iag_queue.sv
module iag_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iag_pkg::elem_t    din,
	input  logic              pop,
	output iag_pkg::elem_t    dout,
	output iag_pkg::q_stat_t  stat
);

	localparam int DEPTH = iag_pkg::QUEUE_DEPTH;
	localparam int PW    = iag_pkg::QPTR_W;
	localparam int NW    = iag_pkg::QCNT_W;

	iag_pkg::elem_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]  count_q;

	// Store on push
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign dout       = entry_q[rd_ptr_q];
	assign stat.full  = count_q == NW'(DEPTH);
	assign stat.empty = count_q == '0;

endmodule

FILE: sv/iag_back.sv
module iag_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iag_pkg::elem_t                      head,
	input  iag_pkg::q_stat_t                    q_stat,
	output logic                                pop,
	input  iag_pkg::geom_t                      geom,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [iag_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                m_tlast,
	output logic [iag_pkg::OUT_USER_W-1:0]      m_tuser
);

	localparam int SW = iag_pkg::SIZE_W;
	localparam int NW = iag_pkg::SPAN_W;
	localparam int HW = iag_pkg::CHH_W;
	localparam int PW = iag_pkg::PROD_W;
	localparam int AW = iag_pkg::ADDR_W;
	localparam int LW = iag_pkg::LIN_W;
	localparam int BW = iag_pkg::BASE_W;
	localparam int DW = iag_pkg::OUT_DATA_W;

	logic          en;
	logic          v_s1, v_s2, v_q;

	logic          bad_s1, last_s1, pad_s1;
	logic [LW-1:0] lin_s1;
	logic [BW-1:0] base_s1;
	logic [SW-1:0] y_s1, x_s1;
	logic [HW-1:0] chh_s1;

	logic          bad_s2, last_s2, pad_s2;
	logic [LW-1:0] lin_s2;
	logic [BW-1:0] base_s2;
	logic [SW-1:0] x_s2;
	logic [PW-1:0] prod_s2;

	logic          bad_q, last_q, pad_q;
	logic [LW-1:0] lin_q;
	logic [AW-1:0] addr_q;

	logic [NW-1:0] ys, xs, yv, xv;
	logic          pad_y, pad_x;
	logic [HW-1:0] row_sum;
	logic [AW-1:0] addr_d;

	// Whole pipeline moves when the output register is empty or its result is taken
	assign en  = !v_q || m_tready;
	assign pop = en && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_stat.empty;
			v_s2 <= v_s1;
			v_q  <= v_s2;
		end
	end

	// Stage 1: source row and column, padding test, channel plane offset
	always_comb begin
		ys    = NW'(head.row_off) + NW'(head.krow);
		xs    = NW'(head.col_off) + NW'(head.kcol);
		yv    = ys - NW'(geom.pad_rows);
		xv    = xs - NW'(geom.pad_cols);
		pad_y = (ys < NW'(geom.pad_rows)) || (yv >= NW'(geom.image_height));
		pad_x = (xs < NW'(geom.pad_cols)) || (xv >= NW'(geom.image_width));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1  <= head.bad;
			last_s1 <= head.last;
			pad_s1  <= pad_y || pad_x;
			lin_s1  <= head.col_index;
			base_s1 <= head.base;
			y_s1    <= yv[SW-1:0];
			x_s1    <= xv[SW-1:0];
			chh_s1  <= HW'(head.chan) * HW'(geom.image_height);
		end
	end

	// Stage 2: row index times image width
	assign row_sum = chh_s1 + HW'(y_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s2  <= bad_s1;
			last_s2 <= last_s1;
			pad_s2  <= pad_s1;
			lin_s2  <= lin_s1;
			base_s2 <= base_s1;
			x_s2    <= x_s1;
			prod_s2 <= PW'(row_sum) * PW'(geom.image_width);
		end
	end

	// Stage 3: add base and column; drop fields for pads and bad geometry
	assign addr_d = AW'(base_s2) + AW'(prod_s2) + AW'(x_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			bad_q  <= bad_s2;
			last_q <= last_s2 && !bad_s2;
			pad_q  <= pad_s2 && !bad_s2;
			lin_q  <= bad_s2 ? '0 : lin_s2;
			addr_q <= (bad_s2 || pad_s2) ? '0 : addr_d;
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = DW'({addr_q, lin_q});
	assign m_tlast  = last_q;
	assign m_tuser  = {bad_q, pad_q};

endmodule

FILE: sv/im2col_address_generator.sv
// im2col / col2im address generator. Each request on the input stream yields one element
// of the lowered column matrix: its column-buffer index and the source pixel address
// image_base + (channel*H + y)*W + x, walked over (channel, kernel row, kernel column)
// rows and output rows/columns, columns fastest. Pad positions carry is_pad with a zero
// address; the final element carries tlast; a kernel larger than the padded image (or a
// zero size or stride) gives a single bad_geometry result with all other fields zero.
// Requests set restart to begin a fresh matrix. The block sustains one element per clock
// while the queue has room and results are taken: the walk counters in the front end decide
// one element per cycle and push it into a four-entry queue; a three-stage address pipeline
// (plane offset multiply, width multiply, base add) drains it. The input stalls after reset
// and in the cycle after every register write while the limits settle, and for as long as
// the queue is full.
module im2col_address_generator #(
	parameter int KERNEL_ROWS = 3,
	parameter int KERNEL_COLS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [iag_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [iag_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [iag_pkg::BASE_W-1:0]          s_tdata,   // [31:0] image_base
	input  logic                                s_tuser,   // [0] restart
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [iag_pkg::OUT_DATA_W-1:0]      m_tdata,   // [37:0] col_index, [70:38] image_address
	output logic                                m_tlast,
	output logic [iag_pkg::OUT_USER_W-1:0]      m_tuser    // [0] is_pad, [1] bad_geometry
);

	iag_pkg::elem_t   elem_in, elem_out;
	iag_pkg::geom_t   geom;
	iag_pkg::q_stat_t q_stat;
	logic             push, pop;

	iag_front #(
		.KERNEL_ROWS(KERNEL_ROWS),
		.KERNEL_COLS(KERNEL_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.elem     (elem_in),
		.geom     (geom)
	);

	iag_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (elem_in),
		.pop   (pop),
		.dout  (elem_out),
		.stat  (q_stat)
	);

	iag_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (elem_out),
		.q_stat  (q_stat),
		.pop     (pop),
		.geom    (geom),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

FILE: sv/iag_checker.sv
module iag_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_write,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [iag_pkg::OUT_DATA_W-1:0]      m_tdata,
	input logic                                m_tlast,
	input logic [iag_pkg::OUT_USER_W-1:0]      m_tuser
);

	// Bad geometry result carries nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tlast && !m_tuser[0])
		else $error("bad geometry result with nonzero fields");

	// Pad result has a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[70:38] == '0))
		else $error("pad result with nonzero address");

	// No request taken right after a register write
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !s_tready)
		else $error("request accepted while limits settle");

	// Stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind im2col_address_generator iag_checker u_iag_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_write(cfg_write),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

FILE: verif/im2col_address_generator_tb.sv
module im2col_address_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iag_pkg::*;

	localparam int K_ROWS        = 3;
	localparam int K_COLS        = 3;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int TOTAL_ITEMS   = 2000;

	// One element of the column matrix as the block should report it
	typedef struct {
		logic [LIN_W-1:0]  col_index;
		logic [ADDR_W-1:0] image_address;
		logic              is_pad;
		logic              last;
		logic              bad_geometry;
	} column_elem_t;

	// Walks the column matrix alongside the block and checks its results in order
	class column_walk_scoreboard;
		logic [SIZE_W-1:0] chans, height, width;
		logic [PAD_W-1:0]  pad_r, pad_c;
		logic [STEP_W-1:0] step_r, step_c;
		logic              scatter;

		logic [CHAN_W-1:0] walk_chan;
		logic [KPOS_W-1:0] walk_krow, walk_kcol;
		logic [POS_W-1:0]  walk_orow, walk_ocol;
		logic [LIN_W-1:0]  walk_lin;

		column_elem_t predicted_elems[$];
		int errors;

		function new();
			chans   = SIZE_W'(1);
			height  = SIZE_W'(1);
			width   = SIZE_W'(1);
			pad_r   = '0;
			pad_c   = '0;
			step_r  = STEP_W'(1);
			step_c  = STEP_W'(1);
			scatter = 1'b0;
			errors  = 0;
			rewind();
		endfunction

		function void rewind();
			walk_chan = '0;
			walk_krow = '0;
			walk_kcol = '0;
			walk_orow = '0;
			walk_ocol = '0;
			walk_lin  = '0;
		endfunction

		function logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
			return (v > SIZE_MAX) ? SIZE_MAX : v;
		endfunction

		function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CHANNEL_COUNT: chans   = clamp_size(data);
				CFG_IMAGE_HEIGHT:  height  = clamp_size(data);
				CFG_IMAGE_WIDTH:   width   = clamp_size(data);
				CFG_PAD_ROWS:      pad_r   = data[PAD_W-1:0];
				CFG_PAD_COLS:      pad_c   = data[PAD_W-1:0];
				CFG_STEP_ROWS:     step_r  = data[STEP_W-1:0];
				CFG_STEP_COLS:     step_c  = data[STEP_W-1:0];
				CFG_SCATTER_MODE:  scatter = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return predicted_elems.size();
		endfunction

		// Work out the element for one accepted request and advance the walk
		function void note_request(logic restart, logic [BASE_W-1:0] base);
			column_elem_t e;
			longint span_r, span_c, rows_out, cols_out, ys, xs, addr;
			bit pad, fin;
			e.col_index     = '0;
			e.image_address = '0;
			e.is_pad        = 1'b0;
			e.last          = 1'b0;
			e.bad_geometry  = 1'b0;
			span_r = longint'(height) + 2 * longint'(pad_r);
			span_c = longint'(width) + 2 * longint'(pad_c);

			// Kernel does not fit or a size or stride is zero: flag it and drop the walk
			if (chans == 0 || height == 0 || width == 0 || step_r == 0 || step_c == 0 ||
			    span_r < K_ROWS || span_c < K_COLS) begin
				rewind();
				e.bad_geometry = 1'b1;
				predicted_elems = {predicted_elems, e};
				return;
			end
			rows_out = (span_r - K_ROWS) / longint'(step_r) + 1;
			cols_out = (span_c - K_COLS) / longint'(step_c) + 1;

			// Restart on request or when a register change left the walk out of bounds
			if (restart || walk_chan >= chans || int'(walk_krow) >= K_ROWS ||
			    int'(walk_kcol) >= K_COLS || longint'(walk_orow) >= rows_out ||
			    longint'(walk_ocol) >= cols_out)
				rewind();

			ys = longint'(walk_orow) * longint'(step_r) + longint'(walk_krow) - longint'(pad_r);
			xs = longint'(walk_ocol) * longint'(step_c) + longint'(walk_kcol) - longint'(pad_c);
			pad = !(ys >= 0 && ys < longint'(height) && xs >= 0 && xs < longint'(width));

			e.col_index = walk_lin;
			if (!pad) begin
				addr = longint'(base) +
				       (longint'(walk_chan) * longint'(height) + ys) * longint'(width) + xs;
				e.image_address = addr[ADDR_W-1:0];
			end
			e.is_pad = pad;
			fin = (longint'(walk_chan) + 1 == longint'(chans)) &&
			      (int'(walk_krow) + 1 == K_ROWS) && (int'(walk_kcol) + 1 == K_COLS) &&
			      (longint'(walk_orow) + 1 == rows_out) && (longint'(walk_ocol) + 1 == cols_out);
			e.last = fin;
			predicted_elems = {predicted_elems, e};

			// Wrap after the final element, else advance columns fastest
			if (fin) begin
				rewind();
				return;
			end
			walk_lin++;
			if (longint'(walk_ocol) + 1 < cols_out) begin
				walk_ocol++;
				return;
			end
			walk_ocol = '0;
			if (longint'(walk_orow) + 1 < rows_out) begin
				walk_orow++;
				return;
			end
			walk_orow = '0;
			if (int'(walk_kcol) + 1 < K_COLS) begin
				walk_kcol++;
				return;
			end
			walk_kcol = '0;
			if (int'(walk_krow) + 1 < K_ROWS) begin
				walk_krow++;
				return;
			end
			walk_krow = '0;
			walk_chan++;
		endfunction

		function void check_field(string name, logic [39:0] want, logic [39:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted result with the oldest predicted element
		function void check_element(logic [OUT_DATA_W-1:0] data, logic tlast,
		                            logic [OUT_USER_W-1:0] user);
			column_elem_t e;
			if (predicted_elems.size() == 0) begin
				$error("result with no request waiting: tdata %0h", data);
				errors++;
				return;
			end
			e = predicted_elems.pop_front();
			check_field("col_index", 40'(e.col_index), 40'(data[LIN_W-1:0]));
			check_field("image_address", 40'(e.image_address),
			            40'(data[LIN_W+ADDR_W-1:LIN_W]));
			check_field("is_pad", 40'(e.is_pad), 40'(user[0]));
			check_field("last", 40'(e.last), 40'(tlast));
			check_field("bad_geometry", 40'(e.bad_geometry), 40'(user[1]));
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [BASE_W-1:0]     s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic [OUT_USER_W-1:0] m_tuser;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req      = 1'b0;

	column_walk_scoreboard sb = new();

	im2col_address_generator #(
		.KERNEL_ROWS(K_ROWS),
		.KERNEL_COLS(K_COLS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Write one register; the caller lowers the write enable after the batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.apply_config(idx, value);
	endtask

	task automatic load_geometry(input logic [CFG_DATA_W-1:0] chans, h, w, pr, pc, sr, sc, sm);
		write_reg(CFG_CHANNEL_COUNT, chans);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_PAD_ROWS, pr);
		write_reg(CFG_PAD_COLS, pc);
		write_reg(CFG_STEP_ROWS, sr);
		write_reg(CFG_STEP_COLS, sc);
		write_reg(CFG_SCATTER_MODE, sm);
		cfg_write <= 1'b0;
	endtask

	// Offer one request after a random gap and hold it until taken
	task automatic send_request(input logic restart, input logic [BASE_W-1:0] base);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= restart;
		s_tdata  <= base;
		do @(posedge clk); while (!s_tready);
		sb.note_request(restart, base);
	endtask

	// Drop valid and wait until every predicted element has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Small register value for a 4-bit field, with junk in the unused upper bits
	function automatic logic [CFG_DATA_W-1:0] with_stray_bits(int lo, int hi);
		return CFG_DATA_W'(($urandom_range(127) << 4) | $urandom_range(hi, lo));
	endfunction

	// Take results, stall at random, and hold off once for a long stretch
	initial begin : result_sink
		int unsigned hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_element(m_tdata, m_tlast, m_tuser);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		logic [BASE_W-1:0] base;
		int kind, sent, budget, pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: a 1x1 image without padding cannot hold the kernel
		send_request(1'b0, 32'h1234_5678);
		drain_results();

		// 1x1 image padded to 3x3: all but the center is pad, the tenth request wraps
		load_geometry(11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0);
		for (int i = 0; i < 10; i++)
			send_request(1'b0, (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0);
		// Restart in the middle of a walk
		for (int i = 0; i < 3; i++)
			send_request(1'b0, $urandom);
		send_request(1'b1, $urandom);
		drain_results();

		// Oversized sizes saturate, widest padding and stride, scatter mode
		load_geometry(11'd2047, 11'd1500, 11'd1025, 11'd15, 11'd15, 11'd15, 11'd15, 11'd1);
		for (int i = 0; i < 3; i++)
			send_request(1'b0, $urandom);
		drain_results();

		// Shrink the geometry under a walk in progress so the walk starts over
		load_geometry(11'd2, 11'd2, 11'd3, 11'd1, 11'd0, 11'd1, 11'd1, 11'd0);
		for (int i = 0; i < 2; i++)
			send_request(1'b0, $urandom);
		drain_results();

		// Zero channel count, then a stride whose low nibble is zero
		load_geometry(11'd0, 11'd4, 11'd4, 11'd0, 11'd0, 11'd1, 11'd1, 11'd0);
		send_request(1'b0, $urandom);
		drain_results();
		load_geometry(11'd1, 11'd4, 11'd4, 11'd0, 11'd0, 11'h7F0, 11'd1, 11'd0);
		send_request(1'b0, $urandom);
		drain_results();

		// Random phases: receiver-heavy idling, sender-heavy idling, then none
		sent = 0;
		for (int regime = 0; regime < 3; regime++) begin
			send_idle_pct = (regime == 0) ? 38 : (regime == 1) ? 73 : 0;
			recv_idle_pct = (regime == 0) ? 73 : (regime == 1) ? 38 : 0;
			while (sent < (regime + 1) * TOTAL_ITEMS / 3) begin
				kind = $urandom_range(9);
				if (kind == 0) begin
					load_geometry(CFG_DATA_W'(1024 + $urandom_range(1023)),
					              CFG_DATA_W'($urandom_range(2047, 1024)),
					              CFG_DATA_W'($urandom_range(2047, 1024)),
					              with_stray_bits(15, 15),
					              with_stray_bits(15, 15), with_stray_bits(1, 15),
					              with_stray_bits(1, 15), CFG_DATA_W'($urandom_range(1)));
					budget = 40;
				end else if (kind == 1) begin
					load_geometry(CFG_DATA_W'($urandom_range(1)),
					              CFG_DATA_W'($urandom_range(2)),
					              CFG_DATA_W'($urandom_range(2)),
					              with_stray_bits(0, 1), with_stray_bits(0, 1),
					              with_stray_bits(0, 1), with_stray_bits(0, 1),
					              CFG_DATA_W'($urandom_range(1)));
					budget = 30;
				end else begin
					load_geometry(CFG_DATA_W'($urandom_range(2, 1)),
					              CFG_DATA_W'($urandom_range(5, 1)),
					              CFG_DATA_W'($urandom_range(5, 1)),
					              with_stray_bits(0, 2), with_stray_bits(0, 2),
					              with_stray_bits(1, 3), with_stray_bits(1, 3),
					              CFG_DATA_W'($urandom_range(1)));
					budget = 120;
				end

				// Mostly one image per matrix; a few restarts and stray bases
				base = $urandom;
				for (int n = 0; n < budget; n++) begin
					if (regime == 2 && !hold_req && n == 20)
						hold_req = 1'b1;
					pick = $urandom_range(99);
					if (pick < 4)
						base = $urandom;
					send_request(pick < 6, (pick >= 96) ? BASE_W'($urandom) : base);
					sent++;
				end
				drain_results();
			end
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("im2col_address_generator_tb: PASS");
		else
			$display("im2col_address_generator_tb: FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#3_000_000;
		$display("im2col_address_generator_tb: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
sv/iag_pkg.sv
sv/iag_front.sv
sv/iag_queue.sv
sv/iag_back.sv
sv/im2col_address_generator.sv
sv/iag_checker.sv
verif/im2col_address_generator_tb.sv
